// File: rtl/assert_macros.svh
// Assertion helpers for the top-level RTL; they compile away under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/c2d_pkg.sv
`default_nettype none

package c2d_pkg;

   localparam int MAX_CHANNELS = 16;
   localparam int MAX_FILTERS  = 16;
   localparam int MAX_KERNEL   = 7;
   localparam int MAX_HEIGHT   = 32;
   localparam int MAX_WIDTH    = 32;

   localparam int KK           = MAX_KERNEL * MAX_KERNEL;
   localparam int HW           = MAX_HEIGHT * MAX_WIDTH;
   localparam int WEIGHT_DEPTH = MAX_FILTERS * MAX_CHANNELS * KK;
   localparam int IMAGE_DEPTH  = MAX_CHANNELS * HW;
   localparam int WADDR_W      = $clog2(WEIGHT_DEPTH);
   localparam int IADDR_W      = $clog2(IMAGE_DEPTH);

   // clamped register widths
   localparam int NC_W = $clog2(MAX_CHANNELS + 1);
   localparam int NF_W = $clog2(MAX_FILTERS + 1);
   localparam int KS_W = $clog2(MAX_KERNEL + 1);
   localparam int H_W  = $clog2(MAX_HEIGHT + 1);
   localparam int W_W  = $clog2(MAX_WIDTH + 1);

   // item fields
   localparam int OP_W      = 2;
   localparam int FILT_W    = 4;
   localparam int CHAN_W    = 4;
   localparam int ROW_W     = 5;
   localparam int COL_W     = 5;
   localparam int VALUE_W   = 16;
   localparam int REQ_DATA_W = 40;
   localparam int SUM_W     = 48;
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int FRAC_SHIFT = 8;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_COUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_SIZE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd4;

   localparam logic [OP_W-1:0] OP_LOAD_WEIGHT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_BIAS   = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD_IMAGE  = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY       = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_WEIGHT,
      CMD_BIAS,
      CMD_IMAGE,
      CMD_QUERY,
      CMD_ERROR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic [WADDR_W-1:0]        waddr;   // load address or query filter base
      logic [IADDR_W-1:0]        iaddr;   // load address or query window origin
      logic [FILT_W-1:0]         filter;
      logic [VALUE_W-1:0]        value;
   } cmd_type;

   typedef struct packed {
      logic [NC_W-1:0] nc;
      logic [NF_W-1:0] nf;
      logic [KS_W-1:0] ks;
      logic [H_W-1:0]  h;
      logic [W_W-1:0]  w;
   } cfg_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef struct packed {
      logic busy;   // a query is in the multiply-accumulate loop
   } bk_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } bk_state_type;

endpackage

`default_nettype wire

// File: rtl/c2d_ram.sv
`default_nettype none

module c2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

`default_nettype wire

// File: rtl/c2d_front.sv
`default_nettype none

module c2d_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [c2d_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic [c2d_pkg::OP_W-1:0]       req_tuser,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [c2d_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [c2d_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire c2d_pkg::q_status_type          q_status,
   output logic                                push,
   output c2d_pkg::cmd_type                    push_cmd,
   output c2d_pkg::cfg_type                    cfg
);

   import c2d_pkg::*;

   logic [4:0] nc_ff, nf_ff;
   logic [2:0] ks_ff;
   logic [5:0] h_ff, w_ff;

   logic [FILT_W-1:0]  f;
   logic [CHAN_W-1:0]  c;
   logic [ROW_W-1:0]   r;
   logic [COL_W-1:0]   k;
   logic [VALUE_W-1:0] v;
   logic               keep;
   logic [6:0]         row_end, col_end;

   assign f = req_tdata[3:0];
   assign c = req_tdata[7:4];
   assign r = req_tdata[12:8];
   assign k = req_tdata[17:13];
   assign v = req_tdata[33:18];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff <= 5'd1;
         nf_ff <= 5'd1;
         ks_ff <= 3'd3;
         h_ff  <= 6'd32;
         w_ff  <= 6'd32;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_CHANNEL_COUNT: nc_ff <= csr_wdata[4:0];
            REG_FILTER_COUNT:  nf_ff <= csr_wdata[4:0];
            REG_KERNEL_SIZE:   ks_ff <= csr_wdata[2:0];
            REG_IMAGE_HEIGHT:  h_ff  <= csr_wdata;
            REG_IMAGE_WIDTH:   w_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // registers below 1 or beyond the store sizes are pulled into range
   always_comb begin
      cfg.nc = (nc_ff == '0) ? NC_W'(1) :
               (nc_ff > MAX_CHANNELS) ? NC_W'(MAX_CHANNELS) : NC_W'(nc_ff);
      cfg.nf = (nf_ff == '0) ? NF_W'(1) :
               (nf_ff > MAX_FILTERS) ? NF_W'(MAX_FILTERS) : NF_W'(nf_ff);
      cfg.ks = (ks_ff == '0) ? KS_W'(1) :
               (ks_ff > MAX_KERNEL) ? KS_W'(MAX_KERNEL) : KS_W'(ks_ff);
      cfg.h  = (h_ff == '0) ? H_W'(1) :
               (h_ff > MAX_HEIGHT) ? H_W'(MAX_HEIGHT) : H_W'(h_ff);
      cfg.w  = (w_ff == '0) ? W_W'(1) :
               (w_ff > MAX_WIDTH) ? W_W'(MAX_WIDTH) : W_W'(w_ff);
   end

   always_comb begin
      row_end         = 7'(r) + 7'(cfg.ks);
      col_end         = 7'(k) + 7'(cfg.ks);
      push_cmd.filter = f;
      push_cmd.value  = v;
      push_cmd.waddr  = WADDR_W'(f) * WADDR_W'(MAX_CHANNELS * KK)
                      + WADDR_W'(c) * WADDR_W'(KK)
                      + WADDR_W'(r) * WADDR_W'(MAX_KERNEL)
                      + WADDR_W'(k);
      push_cmd.iaddr  = IADDR_W'(c) * IADDR_W'(HW)
                      + IADDR_W'(r) * IADDR_W'(MAX_WIDTH)
                      + IADDR_W'(k);
      push_cmd.kind   = CMD_QUERY;
      keep            = 1'b1;
      unique case (req_tuser)
         OP_LOAD_WEIGHT: begin
            push_cmd.kind = CMD_WEIGHT;
            keep = (f < MAX_FILTERS) && (c < MAX_CHANNELS) &&
                   (r < MAX_KERNEL) && (k < MAX_KERNEL);
         end
         OP_LOAD_BIAS: begin
            push_cmd.kind = CMD_BIAS;
            keep = (f < MAX_FILTERS);
         end
         OP_LOAD_IMAGE: begin
            push_cmd.kind = CMD_IMAGE;
            keep = (c < MAX_CHANNELS) && (r < MAX_HEIGHT) && (k < MAX_WIDTH);
         end
         OP_QUERY: begin
            // query carries filter base and window origin at channel 0
            push_cmd.waddr = WADDR_W'(f) * WADDR_W'(MAX_CHANNELS * KK);
            push_cmd.iaddr = IADDR_W'(r) * IADDR_W'(MAX_WIDTH) + IADDR_W'(k);
            if ((NF_W'(f) >= cfg.nf) || (row_end > 7'(cfg.h)) ||
                (col_end > 7'(cfg.w))) begin
               push_cmd.kind = CMD_ERROR;
            end
         end
         default: ;
      endcase
   end

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready && keep;

endmodule

`default_nettype wire

// File: rtl/c2d_queue.sv
`default_nettype none

module c2d_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire c2d_pkg::cmd_type  push_cmd,
   input  wire logic              pop,
   output c2d_pkg::cmd_type       head_cmd,
   output c2d_pkg::q_status_type  q_status
);

   import c2d_pkg::*;

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd       = q_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// File: rtl/c2d_back.sv
`default_nettype none

module c2d_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire c2d_pkg::cfg_type          cfg,
   input  wire c2d_pkg::q_status_type     q_status,
   input  wire c2d_pkg::cmd_type          head_cmd,
   output logic                           pop,
   output c2d_pkg::bk_status_type         bk_status,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [c2d_pkg::SUM_W-1:0]      rsp_tdata,
   output logic                           rsp_tuser
);

   import c2d_pkg::*;

   bk_state_type state_ff, state_in;

   logic [NC_W-1:0]    ch_ff, ch_in;
   logic [KS_W-1:0]    kr_ff, kr_in, kc_ff, kc_in;
   logic [WADDR_W-1:0] w_ch_ff, w_ch_in, w_row_ff, w_row_in;
   logic [IADDR_W-1:0] i_ch_ff, i_ch_in, i_row_ff, i_row_in;

   logic [VALUE_W-1:0] bias_ff [MAX_FILTERS];
   logic               bias_we;

   logic               w_we, i_we;
   logic [WADDR_W-1:0] w_addr;
   logic [IADDR_W-1:0] i_addr;
   logic [VALUE_W-1:0] w_rd, i_rd;

   logic               issue_valid, issue_last;
   logic               rd_valid_ff, rd_last_ff;
   logic               prod_valid_ff, prod_last_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic               rsp_err_ff, rsp_err_in;

   logic [NC_W-1:0]    nc_last;
   logic [KS_W-1:0]    ks_last;
   logic [VALUE_W-1:0] bias_rd;

   assign nc_last = cfg.nc - 1'b1;
   assign ks_last = cfg.ks - 1'b1;
   assign bias_rd = bias_ff[head_cmd.filter];

   c2d_ram #(.WIDTH(VALUE_W), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .addr    (w_addr),
      .wr_data (head_cmd.value),
      .rd_data (w_rd)
   );

   c2d_ram #(.WIDTH(VALUE_W), .DEPTH(IMAGE_DEPTH)) u_image_ram (
      .clock   (clock),
      .wr_en   (i_we),
      .addr    (i_addr),
      .wr_data (head_cmd.value),
      .rd_data (i_rd)
   );

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      kr_in        = kr_ff;
      kc_in        = kc_ff;
      w_ch_in      = w_ch_ff;
      w_row_in     = w_row_ff;
      i_ch_in      = i_ch_ff;
      i_row_in     = i_row_ff;
      pop          = 1'b0;
      w_we         = 1'b0;
      i_we         = 1'b0;
      bias_we      = 1'b0;
      w_addr       = head_cmd.waddr;
      i_addr       = head_cmd.iaddr;
      issue_valid  = 1'b0;
      issue_last   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_err_in   = rsp_err_ff;
      acc_in       = acc_ff;
      if (prod_valid_ff) begin
         acc_in = acc_ff + SUM_W'(prod_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               unique case (head_cmd.kind)
                  CMD_WEIGHT: begin
                     w_we = 1'b1;
                     pop  = 1'b1;
                  end
                  CMD_BIAS: begin
                     bias_we = 1'b1;
                     pop     = 1'b1;
                  end
                  CMD_IMAGE: begin
                     i_we = 1'b1;
                     pop  = 1'b1;
                  end
                  CMD_ERROR: begin
                     if (!rsp_valid_in) begin
                        pop          = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_sum_in   = '0;
                        rsp_err_in   = 1'b1;
                     end
                  end
                  CMD_QUERY: begin
                     // start only with the result register free, so the
                     // finished sum never has to wait
                     if (!rsp_valid_in) begin
                        pop      = 1'b1;
                        ch_in    = '0;
                        kr_in    = '0;
                        kc_in    = '0;
                        w_ch_in  = head_cmd.waddr;
                        w_row_in = head_cmd.waddr;
                        i_ch_in  = head_cmd.iaddr;
                        i_row_in = head_cmd.iaddr;
                        acc_in   = {{(SUM_W - VALUE_W - FRAC_SHIFT){bias_rd[VALUE_W-1]}},
                                    bias_rd, {FRAC_SHIFT{1'b0}}};
                        state_in = ST_RUN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            w_addr      = w_row_ff + WADDR_W'(kc_ff);
            i_addr      = i_row_ff + IADDR_W'(kc_ff);
            issue_valid = 1'b1;
            issue_last  = (ch_ff == nc_last) && (kr_ff == ks_last) && (kc_ff == ks_last);
            if (kc_ff == ks_last) begin
               kc_in = '0;
               if (kr_ff == ks_last) begin
                  kr_in    = '0;
                  ch_in    = ch_ff + 1'b1;
                  w_ch_in  = w_ch_ff + WADDR_W'(KK);
                  w_row_in = w_ch_ff + WADDR_W'(KK);
                  i_ch_in  = i_ch_ff + IADDR_W'(HW);
                  i_row_in = i_ch_ff + IADDR_W'(HW);
               end else begin
                  kr_in    = kr_ff + 1'b1;
                  w_row_in = w_row_ff + WADDR_W'(MAX_KERNEL);
                  i_row_in = i_row_ff + IADDR_W'(MAX_WIDTH);
               end
            end else begin
               kc_in = kc_ff + 1'b1;
            end
            if (issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (prod_valid_ff && prod_last_ff) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_in;
               rsp_err_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_valid_ff   <= 1'b0;
         rd_last_ff    <= 1'b0;
         prod_valid_ff <= 1'b0;
         prod_last_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= issue_valid;
         rd_last_ff    <= issue_last;
         prod_valid_ff <= rd_valid_ff;
         prod_last_ff  <= rd_last_ff;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff      <= ch_in;
      kr_ff      <= kr_in;
      kc_ff      <= kc_in;
      w_ch_ff    <= w_ch_in;
      w_row_ff   <= w_row_in;
      i_ch_ff    <= i_ch_in;
      i_row_ff   <= i_row_in;
      acc_ff     <= acc_in;
      prod_ff    <= $signed(i_rd) * $signed(w_rd);
      rsp_sum_ff <= rsp_sum_in;
      rsp_err_ff <= rsp_err_in;
      if (bias_we) begin
         bias_ff[head_cmd.filter] <= head_cmd.value;
      end
   end

   assign bk_status.busy = (state_ff != ST_IDLE);
   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_tdata      = rsp_sum_ff;
   assign rsp_tuser      = rsp_err_ff;

endmodule

`default_nettype wire

// File: rtl/conv2d_multichannel_forward_unit.sv
`default_nettype none

// Multi-channel 2D convolution (valid padding, stride 1, bias per filter),
// Q8.8 data in, Q32.16 sum out in 48 bits. Load transactions (weight, bias,
// image element) are taken into a four-entry command queue and written to
// the stores while no query runs; loads with an index beyond the store sizes
// are dropped and give no response. A query gives one response: conv_sum
// with error_flag clear, or zero with error_flag set when the filter is not
// in use or the window leaves the image. A valid query feeds its
// channel_count * kernel_size^2 products (up to 784) through the single
// multiply-accumulate from the single-ported weight and image memories, by
// way of a start step, the memory read register and the product register.
// The stores are not cleared at reset, so no clearing pass is needed;
// entries must be written before a query uses them. Configuration writes
// are taken at once and must only happen while idle.

`include "assert_macros.svh"

module conv2d_multichannel_forward_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // filter_index[3:0], channel_index[7:4], row_index[12:8],
   // column_index[17:13], value[33:18], zero[39:34]
   input  wire logic [c2d_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  wire logic [c2d_pkg::OP_W-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // conv_sum[47:0]
   output logic [c2d_pkg::SUM_W-1:0]           rsp_tdata,
   // error_flag[0]
   output logic                                rsp_tuser,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [c2d_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [c2d_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import c2d_pkg::*;

   cfg_type       cfg;
   q_status_type  q_status;
   bk_status_type bk_status;
   cmd_type       push_cmd, head_cmd;
   logic          push, pop;

   c2d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .push       (push),
      .push_cmd   (push_cmd),
      .cfg        (cfg)
   );

   c2d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   c2d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_status   (q_status),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .bk_status  (bk_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `ASSERT_IMPL(a_err_sum_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `ASSERT_IMPL(a_no_pop_busy, clock, reset, bk_status.busy, !pop)
   `ASSERT_IMPL(a_no_push_full, clock, reset, q_status.full, !push)
   `ASSERT_NEXT(a_start_busy, clock, reset,
                pop && !bk_status.busy && head_cmd.kind == CMD_QUERY, bk_status.busy)

endmodule

`default_nettype wire

// File: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import c2d_pkg::*;

   typedef struct packed {
      logic [SUM_W-1:0] conv_sum;
      logic             error_flag;
   } conv_outcome_type;

   // Mirror of the stores and registers; works out each query's answer at acceptance.
   class conv_mirror;
      shortint          weight_mem [MAX_FILTERS][MAX_CHANNELS][MAX_KERNEL][MAX_KERNEL];
      bit               weight_set [MAX_FILTERS][MAX_CHANNELS][MAX_KERNEL][MAX_KERNEL];
      shortint          bias_mem [MAX_FILTERS];
      bit               bias_set [MAX_FILTERS];
      shortint          image_mem [MAX_CHANNELS][MAX_HEIGHT][MAX_WIDTH];
      bit               image_set [MAX_CHANNELS][MAX_HEIGHT][MAX_WIDTH];
      int               chan_raw, filt_raw, ksize_raw, height_raw, width_raw;
      conv_outcome_type sums_due [$];
      int               mismatches;

      function new();
         chan_raw   = 1;
         filt_raw   = 1;
         ksize_raw  = 3;
         height_raw = 32;
         width_raw  = 32;
         mismatches = 0;
      endfunction

      function int clamp_to(int v, int hi);
         if (v < 1) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      function int used_channels();
         return clamp_to(chan_raw, MAX_CHANNELS);
      endfunction

      function int used_filters();
         return clamp_to(filt_raw, MAX_FILTERS);
      endfunction

      function int used_kernel();
         return clamp_to(ksize_raw, MAX_KERNEL);
      endfunction

      function int used_height();
         return clamp_to(height_raw, MAX_HEIGHT);
      endfunction

      function int used_width();
         return clamp_to(width_raw, MAX_WIDTH);
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_CHANNEL_COUNT: chan_raw = int'(data[4:0]);
            REG_FILTER_COUNT:  filt_raw = int'(data[4:0]);
            REG_KERNEL_SIZE:   ksize_raw = int'(data[2:0]);
            REG_IMAGE_HEIGHT:  height_raw = int'(data);
            REG_IMAGE_WIDTH:   width_raw = int'(data);
            default: ;
         endcase
      endfunction

      function void note_item(logic [OP_W-1:0] op, logic [FILT_W-1:0] f,
                              logic [CHAN_W-1:0] c, logic [ROW_W-1:0] r,
                              logic [COL_W-1:0] k, logic [VALUE_W-1:0] v);
         int               nc, ks;
         longint           acc;
         conv_outcome_type res;
         case (op)
            OP_LOAD_WEIGHT: begin
               // kernel row or column beyond the store: dropped
               if (r < MAX_KERNEL && k < MAX_KERNEL) begin
                  weight_mem[f][c][r][k] = v;
                  weight_set[f][c][r][k] = 1'b1;
               end
            end
            OP_LOAD_BIAS: begin
               bias_mem[f] = v;
               bias_set[f] = 1'b1;
            end
            OP_LOAD_IMAGE: begin
               image_mem[c][r][k] = v;
               image_set[c][r][k] = 1'b1;
            end
            OP_QUERY: begin
               nc = used_channels();
               ks = used_kernel();
               if (int'(f) >= used_filters() || int'(r) + ks > used_height() ||
                   int'(k) + ks > used_width()) begin
                  res.conv_sum   = '0;
                  res.error_flag = 1'b1;
               end else begin
                  acc = longint'(bias_mem[f]) * 256;
                  for (int ch = 0; ch < nc; ch++)
                     for (int kr = 0; kr < ks; kr++)
                        for (int kc = 0; kc < ks; kc++)
                           acc += longint'(image_mem[ch][int'(r) + kr][int'(k) + kc]) *
                                  longint'(weight_mem[f][ch][kr][kc]);
                  res.conv_sum   = acc[SUM_W-1:0];
                  res.error_flag = 1'b0;
               end
               sums_due.push_back(res);
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [SUM_W-1:0] sum, logic flag);
         conv_outcome_type due;
         if (sums_due.size() == 0) begin
            $error("unexpected response: conv_sum %0d error_flag %0b", $signed(sum), flag);
            mismatches++;
            return;
         end
         due = sums_due.pop_front();
         if (sum !== due.conv_sum) begin
            $error("conv_sum expected %0d actual %0d", $signed(due.conv_sum), $signed(sum));
            mismatches++;
         end
         if (flag !== due.error_flag) begin
            $error("error_flag expected %0b actual %0b", due.error_flag, flag);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [SUM_W-1:0]      rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   conv_mirror            mirror;
   int                    send_idle = 0;
   int                    recv_stall = 0;
   int                    sent_count = 0;

   // channels, filters, kernel, height, width (raw register values), item count
   int phase_plan [8][6] = '{
      '{1, 1, 3, 32, 32, 110},
      '{2, 3, 2, 5, 6, 100},
      '{0, 31, 1, 1, 1, 50},
      '{1, 2, 7, 32, 32, 90},
      '{31, 17, 0, 63, 0, 90},
      '{3, 4, 7, 6, 9, 60},
      '{4, 2, 3, 8, 8, 110},
      '{1, 16, 5, 12, 7, 100}
   };

   conv2d_multichannel_forward_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= recv_stall);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         mirror.check_result(rsp_tdata, rsp_tuser);
   end

   task automatic send_item(int op, int f, int c, int r, int k, int v);
      int gap;
      gap = 0;
      while (gap < 16 && $urandom_range(99, 0) < send_idle)
         gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op[OP_W-1:0];
      req_tdata  <= {6'b0, v[VALUE_W-1:0], k[COL_W-1:0], r[ROW_W-1:0],
                     c[CHAN_W-1:0], f[FILT_W-1:0]};
      do @(posedge clock); while (!req_tready);
      mirror.note_item(op[OP_W-1:0], f[FILT_W-1:0], c[CHAN_W-1:0], r[ROW_W-1:0],
                       k[COL_W-1:0], v[VALUE_W-1:0]);
      sent_count++;
   endtask

   // wait for every outstanding query, then let queued loads retire
   task automatic settle();
      req_tvalid <= 1'b0;
      while (mirror.sums_due.size() != 0)
         @(posedge clock);
      repeat (32) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      mirror.set_reg(idx, data[CSR_DATA_W-1:0]);
   endtask

   // load whatever a valid query at (f, r, k) would read that is still unwritten
   task automatic fill_footprint(int f, int r, int k);
      int nc, ks;
      nc = mirror.used_channels();
      ks = mirror.used_kernel();
      if (!mirror.bias_set[f])
         send_item(OP_LOAD_BIAS, f, $urandom, $urandom, $urandom, $urandom);
      for (int ch = 0; ch < nc; ch++)
         for (int kr = 0; kr < ks; kr++)
            for (int kc = 0; kc < ks; kc++) begin
               if (!mirror.weight_set[f][ch][kr][kc])
                  send_item(OP_LOAD_WEIGHT, f, ch, kr, kc, $urandom);
               if (!mirror.image_set[ch][r + kr][k + kc])
                  send_item(OP_LOAD_IMAGE, $urandom, ch, r + kr, k + kc, $urandom);
            end
   endtask

   task automatic send_error_query();
      int nf, ks, row_lo, col_lo, sel, f, r, k;
      nf = mirror.used_filters();
      ks = mirror.used_kernel();
      row_lo = mirror.used_height() - ks + 1;
      col_lo = mirror.used_width() - ks + 1;
      if (row_lo < 0) row_lo = 0;
      if (col_lo < 0) col_lo = 0;
      do sel = $urandom_range(2, 0);
      while (!((sel == 0 && nf < MAX_FILTERS) || (sel == 1 && row_lo <= 31) ||
               (sel == 2 && col_lo <= 31)));
      f = (sel == 0) ? $urandom_range(MAX_FILTERS - 1, nf) : $urandom_range(nf - 1, 0);
      r = (sel == 1) ? $urandom_range(31, row_lo) : $urandom_range(31, 0);
      k = (sel == 2) ? $urandom_range(31, col_lo) : $urandom_range(31, 0);
      send_item(OP_QUERY, f, $urandom, r, k, $urandom);
   endtask

   task automatic send_valid_query();
      int ks, f, r, k;
      ks = mirror.used_kernel();
      if (ks > mirror.used_height() || ks > mirror.used_width()) begin
         send_error_query();
      end else begin
         f = $urandom_range(mirror.used_filters() - 1, 0);
         r = $urandom_range(mirror.used_height() - ks, 0);
         k = $urandom_range(mirror.used_width() - ks, 0);
         fill_footprint(f, r, k);
         send_item(OP_QUERY, f, $urandom, r, k, $urandom);
      end
   endtask

   // every accepted transaction counts towards the phase, footprint loads included
   task automatic run_phase(int count);
      int start, pick, op, ks;
      start = sent_count;
      while (sent_count - start < count) begin
         pick = $urandom_range(99, 0);
         ks = mirror.used_kernel();
         if (pick < 45) begin
            send_valid_query();
         end else if (pick < 55) begin
            send_error_query();
         end else if (pick < 88) begin
            // overwrite inside the area in use
            op = $urandom_range(2, 0);
            if (op == OP_LOAD_WEIGHT)
               send_item(OP_LOAD_WEIGHT, $urandom_range(mirror.used_filters() - 1, 0),
                         $urandom_range(mirror.used_channels() - 1, 0),
                         $urandom_range(ks - 1, 0), $urandom_range(ks - 1, 0), $urandom);
            else if (op == OP_LOAD_BIAS)
               send_item(OP_LOAD_BIAS, $urandom_range(mirror.used_filters() - 1, 0),
                         $urandom, $urandom, $urandom, $urandom);
            else
               send_item(OP_LOAD_IMAGE, $urandom,
                         $urandom_range(mirror.used_channels() - 1, 0),
                         $urandom_range(mirror.used_height() - 1, 0),
                         $urandom_range(mirror.used_width() - 1, 0), $urandom);
         end else begin
            // anywhere in the index space; most weight loads here are dropped
            send_item($urandom_range(2, 0), $urandom, $urandom, $urandom, $urandom,
                      $urandom);
         end
      end
   endtask

   task automatic directed_items();
      logic [VALUE_W-1:0] w;
      send_item(OP_LOAD_BIAS, 0, 0, 0, 0, 16'h8000);
      for (int kr = 0; kr < 3; kr++)
         for (int kc = 0; kc < 3; kc++) begin
            w = VALUE_W'($urandom);
            if (kr == 0 && kc == 0) w = 16'h7fff;
            if (kr == 2 && kc == 2) w = 16'h8000;
            send_item(OP_LOAD_WEIGHT, 0, 0, kr, kc, w);
         end
      // bottom-right corner of the image at full negative scale
      for (int r = 29; r < 32; r++)
         for (int k = 29; k < 32; k++)
            send_item(OP_LOAD_IMAGE, 0, 0, r, k, 16'h8000);
      send_item(OP_LOAD_WEIGHT, 15, 15, 6, 6, 16'h7fff);
      send_item(OP_LOAD_WEIGHT, 15, 15, 31, 7, 16'h1234);
      send_item(OP_LOAD_BIAS, 15, 0, 0, 0, 16'h7fff);
      send_item(OP_QUERY, 0, 0, 29, 29, 16'h0000);
      send_item(OP_QUERY, 0, 0, 30, 29, 16'hffff);
      send_item(OP_QUERY, 0, 15, 29, 30, 16'h0000);
      send_item(OP_QUERY, 15, 0, 0, 0, 16'h0000);
   endtask

   initial begin
      mirror = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle  = 27;
      recv_stall = 73;
      directed_items();
      for (int p = 0; p < 8; p++) begin
         if (p == 3) begin
            send_idle  = 73;
            recv_stall = 27;
         end
         if (p == 6) begin
            send_idle  = 0;
            recv_stall = 0;
         end
         if (p == 0) begin
            run_phase(phase_plan[p][5] / 2);
            settle();
            run_phase(phase_plan[p][5] - phase_plan[p][5] / 2);
         end else begin
            settle();
            write_reg(REG_CHANNEL_COUNT, phase_plan[p][0]);
            write_reg(REG_FILTER_COUNT, phase_plan[p][1]);
            write_reg(REG_KERNEL_SIZE, phase_plan[p][2]);
            write_reg(REG_IMAGE_HEIGHT, phase_plan[p][3]);
            write_reg(REG_IMAGE_WIDTH, phase_plan[p][4]);
            csr_valid <= 1'b0;
            run_phase(phase_plan[p][5]);
         end
      end
      settle();
      if (mirror.mismatches == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb NOT OK");
      $finish;
   end

endmodule
